// ----- rtl/register_slot_allocator_assert.svh -----
// assertion macros shared by the allocator rtl
// each macro expects signals named clk and rst_n in the enclosing module
`ifndef REGISTER_SLOT_ALLOCATOR_ASSERT_SVH
`define REGISTER_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define RSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rsa_pkg
// types and constants of the register / stack slot allocator
// ----------------------------------------------------------------------------
package rsa_pkg;

  // default sizes
  localparam int NUM_REGS_DEF    = 32;
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int BLOCK_BITS_DEF  = 16;

  // largest value in bytes that still fits a register
  localparam logic [15:0] REG_SIZE_LIMIT = 16'd8;

  // action codes
  localparam logic ACT_DECLARE  = 1'b0;
  localparam logic ACT_ALLOCATE = 1'b1;

  // location of an entry
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_REG   = 2'd1,
    KIND_STACK = 2'd2
  } kind_t;

  // control states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  // input transaction
  typedef struct packed {
    logic        action;
    logic [7:0]  entry_index;
    logic [15:0] value_size;
    logic [15:0] lifetime_end;
    logic [15:0] current_block;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [7:0]  new_index;
    logic [1:0]  location_kind;
    logic [4:0]  register_number;
    logic [15:0] stack_slot;
    logic        error;
  } out_t;

endpackage

// ----- rtl/rsa_ram.sv -----
// ----------------------------------------------------------------------------
// rsa_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/register_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// register_slot_allocator
// linear-scan allocator: gives each declared value a register or a stack slot
// ----------------------------------------------------------------------------
//
//  channel  | ports                        | moves
//  ---------+------------------------------+-------------------------------
//  input    | in_valid, in_stall, in_data  | declare / allocate transaction
//  result   | out_valid, out_stall, out_data | one result per transaction
//
//  declare and rejected allocate skip the walk; a good allocate runs the
//  expiry walk, which reads one table entry per cycle from the entry ram.
//  reset clears the entry count, register map and slot counter; the table
//  ram needs no clearing since only declared entries are ever read.
//  a result waits in the output register while out_stall is high.
//
module register_slot_allocator #(
  parameter int NUM_REGS    = rsa_pkg::NUM_REGS_DEF,
  parameter int MAX_ENTRIES = rsa_pkg::MAX_ENTRIES_DEF,
  parameter int BLOCK_BITS  = rsa_pkg::BLOCK_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rsa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rsa_pkg::out_t out_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int RB = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int WW = BLOCK_BITS + 2 + RB;

  rsa_pkg::state_t       state_r, state_nxt;
  rsa_pkg::in_t          item_r;
  logic [CW-1:0]         count_r;
  logic [NUM_REGS-1:0]   busy_r, busy_nxt;
  logic [15:0]           slot_r;
  logic [CW-1:0]         walk_addr_r;
  logic                  rd_vld_r;
  logic [IW-1:0]         rd_addr_r;
  logic                  out_valid_r;
  rsa_pkg::out_t         out_r, res;

  logic                  in_acc, out_ready, is_alloc, idx_bad, full, fin_err;
  logic                  walk_done, issue, commit;
  logic [IW-1:0]         idx_addr;
  logic [BLOCK_BITS-1:0] last_blk, cur_blk;
  logic [WW-1:0]         rdata, wdata;
  logic [IW-1:0]         waddr;
  logic                  we;
  logic [BLOCK_BITS-1:0] rd_last;
  rsa_pkg::kind_t        rd_kind;
  logic [RB-1:0]         rd_reg;
  logic                  rd_is_idx, free_hit, wb_walk;
  logic                  free_found, use_reg;
  logic [RB-1:0]         free_reg;

  // handshakes
  assign in_stall  = (state_r != rsa_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // decode of the held transaction
  assign is_alloc = (item_r.action == rsa_pkg::ACT_ALLOCATE);
  assign idx_bad  = 32'(item_r.entry_index) >= 32'(count_r);
  assign full     = 32'(count_r) == 32'(MAX_ENTRIES);
  assign fin_err  = is_alloc ? idx_bad : full;
  assign idx_addr = IW'(item_r.entry_index);
  assign last_blk = BLOCK_BITS'(item_r.lifetime_end);
  assign cur_blk  = BLOCK_BITS'(item_r.current_block);

  // entry word fields returned by the ram
  assign rd_last   = rdata[WW-1 -: BLOCK_BITS];
  assign rd_kind   = rsa_pkg::kind_t'(rdata[RB+1:RB]);
  assign rd_reg    = rdata[RB-1:0];
  assign rd_is_idx = (rd_addr_r == idx_addr);

  // expiry check; the named entry always gives its register back
  assign free_hit = rd_vld_r && (rd_kind == rsa_pkg::KIND_REG) &&
                    (rd_is_idx || (rd_last < cur_blk));
  assign wb_walk  = free_hit && !rd_is_idx;

  // lowest free register
  always_comb begin
    free_found = 1'b0;
    free_reg   = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_reg   = RB'(i);
      end
    end
  end

  assign use_reg = (item_r.value_size <= rsa_pkg::REG_SIZE_LIMIT) && free_found;

  // walk and commit control
  assign walk_done = idx_bad || (walk_addr_r == count_r);
  assign issue     = (state_r == rsa_pkg::S_WALK) && !walk_done;
  assign commit    = (state_r == rsa_pkg::S_FINISH) && out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsa_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.action == rsa_pkg::ACT_ALLOCATE) ? rsa_pkg::S_WALK
                                                                 : rsa_pkg::S_FINISH;
        end
      end
      rsa_pkg::S_WALK: begin
        if (walk_done) begin
          state_nxt = rsa_pkg::S_FINISH;
        end
      end
      rsa_pkg::S_FINISH: begin
        if (out_ready) begin
          state_nxt = rsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = rsa_pkg::S_IDLE;
    endcase
  end

  // result and table write
  always_comb begin
    res   = '0;
    we    = 1'b0;
    waddr = idx_addr;
    wdata = '0;
    if (fin_err) begin
      res.error = 1'b1;
    end else if (!is_alloc) begin
      res.new_index = 8'(count_r);
    end else if (use_reg) begin
      res.location_kind   = rsa_pkg::KIND_REG;
      res.register_number = 5'(free_reg);
    end else begin
      res.location_kind = rsa_pkg::KIND_STACK;
      res.stack_slot    = slot_r;
    end
    if (wb_walk) begin
      we    = 1'b1;
      waddr = rd_addr_r;
      wdata = {rd_last, rsa_pkg::KIND_NONE, RB'(0)};
    end else if (commit && !fin_err) begin
      we = 1'b1;
      if (is_alloc) begin
        waddr = idx_addr;
        wdata = {last_blk, rsa_pkg::kind_t'(res.location_kind),
                 use_reg ? free_reg : RB'(0)};
      end else begin
        waddr = IW'(count_r);
        wdata = {BLOCK_BITS'(0), rsa_pkg::KIND_NONE, RB'(0)};
      end
    end
  end

  // register map update
  always_comb begin
    busy_nxt = busy_r;
    if (free_hit) begin
      busy_nxt = busy_nxt & ~(NUM_REGS'(1) << rd_reg);
    end
    if (commit && is_alloc && !idx_bad && use_reg) begin
      busy_nxt = busy_nxt | (NUM_REGS'(1) << free_reg);
    end
  end

  // entry table
  rsa_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (walk_addr_r[IW-1:0]),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsa_pkg::S_IDLE;
      count_r     <= '0;
      busy_r      <= '0;
      slot_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      rd_vld_r <= issue;
      if (commit && !fin_err && !is_alloc) begin
        count_r <= count_r + CW'(1);
      end
      if (commit && !fin_err && is_alloc && !use_reg) begin
        slot_r <= slot_r + 16'd1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r      <= in_data;
      walk_addr_r <= '0;
    end else if (issue) begin
      walk_addr_r <= walk_addr_r + CW'(1);
    end
    rd_addr_r <= walk_addr_r[IW-1:0];
    if (commit) begin
      out_r <= res;
    end
  end

  // checks
  `include "register_slot_allocator_assert.svh"

  `RSA_ASSERT_NOW(a_walk_bound, state_r == rsa_pkg::S_WALK, walk_addr_r <= count_r, "walk past table end")
  `RSA_ASSERT_NOW(a_rd_in_walk, rd_vld_r, state_r == rsa_pkg::S_WALK, "table read outside walk")
  `RSA_ASSERT_NEXT(a_reg_taken, commit && is_alloc && !idx_bad && use_reg, busy_r[$past(free_reg)], "granted register not busy")
  `RSA_ASSERT_NEXT(a_slot_step, commit && is_alloc && !idx_bad && !use_reg, slot_r == $past(slot_r) + 16'd1, "slot counter not advanced")

endmodule
